>>> rtl/core/gpla_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gpla_pkg;

  // Default widths of the converter code and of the ppm result.
  localparam int ADC_BITS_DEF = 12;
  localparam int PPM_BITS_DEF = 14;

  // Width of the threshold registers and of the configuration data port.
  localparam int CFG_W = 14;
  localparam int CFG_IDX_W = 2;

  // Fixed-point mantissa: Q30 in [1,2) needs 31 bits.
  localparam int Q_FRAC = 30;
  localparam int MANT_W = 31;
  localparam int LOG_FRAC = 16;
  localparam int MUL_W = 32;

  // log2(ppm) = LOG_OFFSET + LOG_SLOPE * (L(15d) - L(full - d)), all in Q16.
  localparam int LOG_OFFSET = 354861;
  localparam int LOG_SLOPE = 30802;

  typedef enum logic [2:0] {
    OP_SAMPLE  = 3'd0,
    OP_TOGGLE  = 3'd1,
    OP_PWR_ON  = 3'd2,
    OP_PWR_OFF = 3'd3,
    OP_RESET   = 3'd4
  } gpla_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW   = 2'd0,
    CFG_HIGH  = 2'd1,
    CFG_ALARM = 2'd2
  } gpla_cfg_e;

  typedef struct packed {
    logic blue;
    logic green;
    logic red;
    logic buzz;
    logic relay;
  } drive_t;

  localparam drive_t DRV_BLUE    = 5'b10000;
  localparam drive_t DRV_GREEN   = 5'b01000;
  localparam drive_t DRV_LEVEL1  = 5'b01100;
  localparam drive_t DRV_LEVEL2  = 5'b00101;
  localparam drive_t DRV_LEVEL3  = 5'b00111;

  localparam logic [2:0] BLINK_OFF = 3'd0;
  localparam logic [2:0] BLINK_1HZ = 3'd1;
  localparam logic [2:0] BLINK_5HZ = 3'd5;

  localparam logic [CFG_W-1:0] LOW_RST   = 14'd50;
  localparam logic [CFG_W-1:0] HIGH_RST  = 14'd150;
  localparam logic [CFG_W-1:0] ALARM_RST = 14'd300;

  // Table of 2^(2^-k) in Q30, entry i holding k = 16 - i.
  typedef logic [LOG_FRAC-1:0][MANT_W-1:0] coef_tbl_t;

  // Exact floor square root; evaluated at elaboration only.
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bt;
    logic [63:0] rem;
    res = 64'd0;
    bt  = 64'h4000_0000_0000_0000;
    rem = v;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bt) begin
        rem = rem - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic coef_tbl_t coef_table();
    coef_tbl_t   tbl;
    logic [63:0] c;
    c = isqrt64(64'd1 << 61);
    for (int k = LOG_FRAC - 1; k >= 0; k--) begin
      tbl[k] = c[MANT_W-1:0];
      c = isqrt64(c << Q_FRAC);
    end
    return tbl;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/gpla_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gpla_in_if #(
  parameter int ADC_BITS = gpla_pkg::ADC_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [2:0]          op;
  logic [ADC_BITS-1:0] adc_code;

  modport source (output valid, output op, output adc_code, input ready);
  modport sink   (input valid, input op, input adc_code, output ready);
endinterface

`default_nettype wire

>>> rtl/core/gpla_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gpla_out_if #(
  parameter int PPM_BITS = gpla_pkg::PPM_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [PPM_BITS-1:0] ppm;
  logic [2:0]          level;
  logic                level_changed;
  logic                powered;
  logic                relay_on;
  logic                buzzer_on;
  logic                led_red;
  logic                led_green;
  logic                led_blue;
  logic [2:0]          blink_hz;

  modport source (
    output valid, output ppm, output level, output level_changed, output powered,
    output relay_on, output buzzer_on, output led_red, output led_green,
    output led_blue, output blink_hz, input ready
  );
  modport sink (
    input valid, input ppm, input level, input level_changed, input powered,
    input relay_on, input buzzer_on, input led_red, input led_green,
    input led_blue, input blink_hz, output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/gpla_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared unsigned multiplier; the sequencer registers its product.
module gpla_mul (
  input  wire logic [gpla_pkg::MUL_W-1:0]   a_i,
  input  wire logic [gpla_pkg::MUL_W-1:0]   b_i,
  output logic      [2*gpla_pkg::MUL_W-1:0] p_o
);

  assign p_o = (2*gpla_pkg::MUL_W)'(a_i) * (2*gpla_pkg::MUL_W)'(b_i);

endmodule

`default_nettype wire

>>> rtl/core/gpla_ppm_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module gpla_ppm_unit #(
  parameter int ADC_BITS = gpla_pkg::ADC_BITS_DEF,
  parameter int PPM_BITS = gpla_pkg::PPM_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [ADC_BITS-1:0] code_i,
  output logic                     done_o,
  output logic      [PPM_BITS-1:0] ppm_o
);

  localparam int XW = ADC_BITS + 4;
  localparam int EW = $clog2(XW);
  localparam int LW = EW + gpla_pkg::LOG_FRAC;
  localparam int YW = LW + 3;
  localparam int NW = $clog2(PPM_BITS);
  localparam int MW = gpla_pkg::MANT_W;
  localparam int PW = 2 * gpla_pkg::MUL_W;
  localparam int FW = gpla_pkg::LOG_FRAC;
  localparam logic [ADC_BITS-1:0] FULL = {ADC_BITS{1'b1}};
  localparam logic [PPM_BITS-1:0] PPM_MAX = {PPM_BITS{1'b1}};
  localparam gpla_pkg::coef_tbl_t COEF = gpla_pkg::coef_table();

  typedef enum logic [3:0] {
    U_IDLE, U_NORM, U_SQ, U_DIFF, U_MUL, U_YCHK, U_EXP, U_OUT
  } ustate_e;

  ustate_e             state_q, state_d;
  logic [3:0]          cnt_q, cnt_d;
  logic                phase_q, phase_d;
  logic [ADC_BITS-1:0] d_q, d_d;
  logic [MW-1:0]       m_q, m_d;
  logic [LW-1:0]       r_q, r_d;
  logic [LW-1:0]       l1_q, l1_d;
  logic [LW-1:0]       mag_q, mag_d;
  logic                neg_q, neg_d;
  logic [LW-1:0]       q_q, q_d;
  logic [FW-1:0]       f_q, f_d;
  logic [NW-1:0]       n_q, n_d;
  logic                done_q, done_d;
  logic [PPM_BITS-1:0] ppm_q, ppm_d;

  logic [XW-1:0]                 x;
  logic [EW-1:0]                 e;
  logic [gpla_pkg::MUL_W-1:0]    mul_a, mul_b;
  logic [PW-1:0]                 prod;
  logic [MW:0]                   sq;
  logic signed [LW:0]            t;
  logic signed [YW-1:0]          y;
  logic [YW-FW-1:0]              n_full;
  logic [MW-1:0]                 v;

  gpla_mul u_mul (
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (prod)
  );

  // Operand of the logarithm: 15*d first, then full - d.
  assign x = phase_q ? XW'(FULL - d_q) : ((XW'(d_q) << 4) - XW'(d_q));

  always_comb begin
    e = '0;
    for (int i = 0; i < XW; i++) begin
      if (x[i]) begin
        e = EW'(i);
      end
    end
  end

  always_comb begin
    case (state_q)
      U_SQ: begin
        mul_a = gpla_pkg::MUL_W'(m_q);
        mul_b = gpla_pkg::MUL_W'(m_q);
      end
      U_MUL: begin
        mul_a = gpla_pkg::MUL_W'(mag_q);
        mul_b = gpla_pkg::MUL_W'(gpla_pkg::LOG_SLOPE);
      end
      U_EXP: begin
        mul_a = gpla_pkg::MUL_W'(m_q);
        mul_b = gpla_pkg::MUL_W'(COEF[cnt_q]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign sq     = prod[gpla_pkg::Q_FRAC+MW:gpla_pkg::Q_FRAC];
  assign t      = $signed({1'b0, l1_q}) - $signed({1'b0, r_q});
  assign y      = neg_q ? (YW'(gpla_pkg::LOG_OFFSET) - YW'(q_q))
                        : (YW'(gpla_pkg::LOG_OFFSET) + YW'(q_q));
  assign n_full = y[YW-1:FW];
  assign v      = m_q >> (5'(gpla_pkg::Q_FRAC) - 5'(n_q));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    phase_d = phase_q;
    d_d     = d_q;
    m_d     = m_q;
    r_d     = r_q;
    l1_d    = l1_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    q_d     = q_q;
    f_d     = f_q;
    n_d     = n_q;
    done_d  = 1'b0;
    ppm_d   = ppm_q;
    case (state_q)
      U_IDLE: begin
        if (start_i) begin
          d_d     = code_i;
          phase_d = 1'b0;
          if (code_i == '0) begin
            ppm_d  = '0;
            done_d = 1'b1;
          end else if (code_i == FULL) begin
            ppm_d  = PPM_MAX;
            done_d = 1'b1;
          end else begin
            state_d = U_NORM;
          end
        end
      end
      U_NORM: begin
        // Put the leading one of x at bit 30 to get the Q30 mantissa.
        m_d     = MW'(x) << (5'(gpla_pkg::Q_FRAC) - 5'(e));
        r_d     = {e, {FW{1'b0}}};
        cnt_d   = 4'(FW - 1);
        state_d = U_SQ;
      end
      U_SQ: begin
        if (sq[MW]) begin
          m_d        = sq[MW:1];
          r_d[cnt_q] = 1'b1;
        end else begin
          m_d = sq[MW-1:0];
        end
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd0) begin
          if (!phase_q) begin
            l1_d    = r_d;
            phase_d = 1'b1;
            state_d = U_NORM;
          end else begin
            state_d = U_DIFF;
          end
        end
      end
      U_DIFF: begin
        neg_d   = t[LW];
        mag_d   = t[LW] ? LW'(-t) : LW'(t);
        state_d = U_MUL;
      end
      U_MUL: begin
        // Magnitude of the scaled log, truncated toward zero.
        q_d     = prod[LW+FW-1:FW];
        state_d = U_YCHK;
      end
      U_YCHK: begin
        if (y < 0) begin
          ppm_d   = '0;
          done_d  = 1'b1;
          state_d = U_IDLE;
        end else if (n_full >= (YW-FW)'(PPM_BITS)) begin
          ppm_d   = PPM_MAX;
          done_d  = 1'b1;
          state_d = U_IDLE;
        end else begin
          n_d     = n_full[NW-1:0];
          f_d     = y[FW-1:0];
          m_d     = MW'(1) << gpla_pkg::Q_FRAC;
          cnt_d   = 4'(FW - 1);
          state_d = U_EXP;
        end
      end
      U_EXP: begin
        if (f_q[cnt_q]) begin
          m_d = prod[gpla_pkg::Q_FRAC+MW-1:gpla_pkg::Q_FRAC];
        end
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd0) begin
          state_d = U_OUT;
        end
      end
      U_OUT: begin
        ppm_d   = (v > MW'(PPM_MAX)) ? PPM_MAX : v[PPM_BITS-1:0];
        done_d  = 1'b1;
        state_d = U_IDLE;
      end
      default: begin
        state_d = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    phase_q <= phase_d;
    d_q     <= d_d;
    m_q     <= m_d;
    r_q     <= r_d;
    l1_q    <= l1_d;
    mag_q   <= mag_d;
    neg_q   <= neg_d;
    q_q     <= q_d;
    f_q     <= f_d;
    n_q     <= n_d;
    ppm_q   <= ppm_d;
  end

  assign done_o = done_q;
  assign ppm_o  = ppm_q;

endmodule

`default_nettype wire

>>> rtl/core/gas_ppm_level_alarm_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Gas level alarm core. Each input item carries an op (sample, toggle power, power
// on, power off, reset) and a converter code, and gives exactly one result item
// that shows the stored ppm, the warning level, whether this item moved the level,
// the power flag and the relay, buzzer, lamp and blink drives. A sample taken while
// powered is turned into ppm by a fixed-point log2 / exp2 sequence that runs on one
// shared 32 by 32 multiplier: two logarithms of 16 squarings each, one scaling
// product and 16 exponent products. A code of zero or full scale skips that
// sequence, and every other op has its result ready in the cycle after acceptance.
// The block takes one item at a time: a new item is accepted once the previous
// result has been taken or is being taken in the same cycle. Threshold registers
// are written through the plain write port; the user must write them only while
// the block is idle, which the block itself does not enforce. They take effect on
// the next sample.
module gas_ppm_level_alarm_core #(
  parameter int ADC_BITS = gpla_pkg::ADC_BITS_DEF,
  parameter int PPM_BITS = gpla_pkg::PPM_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  gpla_in_if.sink                                 in_i,
  gpla_out_if.source                              out_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [gpla_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [gpla_pkg::CFG_W-1:0]         cfg_data_i
);

  // Common width for comparing the ppm against the threshold registers.
  localparam int CW = (PPM_BITS > gpla_pkg::CFG_W) ? PPM_BITS : gpla_pkg::CFG_W;

  typedef enum logic {
    S_IDLE,
    S_CALC
  } state_e;

  state_e                     state_q, state_d;
  logic                       power_q, power_d;
  logic [1:0]                 level_q, level_d;
  logic [PPM_BITS-1:0]        ppm_q, ppm_d;
  gpla_pkg::drive_t           drive_q, drive_d;
  logic [2:0]                 blink_q, blink_d;
  logic                       changed_q, changed_d;
  logic                       out_valid_q, out_valid_d;
  logic [gpla_pkg::CFG_W-1:0] low_q, low_d;
  logic [gpla_pkg::CFG_W-1:0] high_q, high_d;
  logic [gpla_pkg::CFG_W-1:0] alarm_q, alarm_d;

  logic                in_ready;
  logic                in_fire;
  logic                calc_start;
  logic                calc_done;
  logic [PPM_BITS-1:0] calc_ppm;
  logic [1:0]          grade;

  gpla_ppm_unit #(
    .ADC_BITS (ADC_BITS),
    .PPM_BITS (PPM_BITS)
  ) u_ppm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (calc_start),
    .code_i  (ADC_BITS'(in_i.adc_code)),
    .done_o  (calc_done),
    .ppm_o   (calc_ppm)
  );

  // The input side opens only while idle and when the result slot is free or drains this cycle.
  assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign in_fire  = in_i.valid && in_ready;

  // Grade the freshly computed ppm against the three thresholds.
  always_comb begin
    if (CW'(calc_ppm) < CW'(low_q)) begin
      grade = 2'd0;
    end else if (CW'(calc_ppm) < CW'(high_q)) begin
      grade = 2'd1;
    end else if (CW'(calc_ppm) < CW'(alarm_q)) begin
      grade = 2'd2;
    end else begin
      grade = 2'd3;
    end
  end

  always_comb begin
    state_d     = state_q;
    power_d     = power_q;
    level_d     = level_q;
    ppm_d       = ppm_q;
    drive_d     = drive_q;
    blink_d     = blink_q;
    changed_d   = changed_q;
    out_valid_d = out_valid_q && !out_o.ready;
    low_d       = low_q;
    high_d      = high_q;
    alarm_d     = alarm_q;
    calc_start  = 1'b0;

    if (cfg_we_i) begin
      case (gpla_pkg::gpla_cfg_e'(cfg_idx_i))
        gpla_pkg::CFG_LOW:   low_d   = cfg_data_i;
        gpla_pkg::CFG_HIGH:  high_d  = cfg_data_i;
        gpla_pkg::CFG_ALARM: alarm_d = cfg_data_i;
        default: ;
      endcase
    end

    if (in_fire) begin
      // Every op except a sample that is handed to the ppm unit answers at once.
      changed_d   = 1'b0;
      out_valid_d = 1'b1;
      case (gpla_pkg::gpla_op_e'(in_i.op))
        gpla_pkg::OP_SAMPLE: begin
          if (power_q) begin
            calc_start  = 1'b1;
            out_valid_d = 1'b0;
            state_d     = S_CALC;
          end
        end
        gpla_pkg::OP_TOGGLE: begin
          power_d = !power_q;
          drive_d = power_q ? gpla_pkg::DRV_GREEN : gpla_pkg::DRV_BLUE;
          blink_d = gpla_pkg::BLINK_OFF;
        end
        gpla_pkg::OP_PWR_ON: begin
          power_d = 1'b1;
          drive_d = gpla_pkg::DRV_BLUE;
          blink_d = gpla_pkg::BLINK_OFF;
        end
        gpla_pkg::OP_PWR_OFF: begin
          power_d = 1'b0;
          drive_d = gpla_pkg::DRV_GREEN;
          blink_d = gpla_pkg::BLINK_OFF;
        end
        gpla_pkg::OP_RESET: begin
          level_d = 2'd0;
          ppm_d   = '0;
          power_d = 1'b1;
          drive_d = gpla_pkg::DRV_BLUE;
          blink_d = gpla_pkg::BLINK_OFF;
        end
        default: ;
      endcase
    end

    if (state_q == S_CALC && calc_done) begin
      // The ppm is always stored; the drive only follows a change of level.
      ppm_d       = calc_ppm;
      out_valid_d = 1'b1;
      state_d     = S_IDLE;
      if (grade != level_q) begin
        level_d   = grade;
        changed_d = 1'b1;
        case (grade)
          2'd0: begin
            drive_d = gpla_pkg::DRV_BLUE;
            blink_d = gpla_pkg::BLINK_OFF;
          end
          2'd1: begin
            drive_d = gpla_pkg::DRV_LEVEL1;
            blink_d = gpla_pkg::BLINK_OFF;
          end
          2'd2: begin
            drive_d = gpla_pkg::DRV_LEVEL2;
            blink_d = gpla_pkg::BLINK_1HZ;
          end
          default: begin
            drive_d = gpla_pkg::DRV_LEVEL3;
            blink_d = gpla_pkg::BLINK_5HZ;
          end
        endcase
      end else begin
        changed_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      power_q     <= 1'b1;
      level_q     <= 2'd0;
      ppm_q       <= '0;
      drive_q     <= gpla_pkg::DRV_BLUE;
      blink_q     <= gpla_pkg::BLINK_OFF;
      changed_q   <= 1'b0;
      out_valid_q <= 1'b0;
      low_q       <= gpla_pkg::LOW_RST;
      high_q      <= gpla_pkg::HIGH_RST;
      alarm_q     <= gpla_pkg::ALARM_RST;
    end else begin
      state_q     <= state_d;
      power_q     <= power_d;
      level_q     <= level_d;
      ppm_q       <= ppm_d;
      drive_q     <= drive_d;
      blink_q     <= blink_d;
      changed_q   <= changed_d;
      out_valid_q <= out_valid_d;
      low_q       <= low_d;
      high_q      <= high_d;
      alarm_q     <= alarm_d;
    end
  end

  // The stored state only changes when a result is loaded, and no item is taken
  // while a result waits, so the state registers are the result payload.
  assign in_i.ready          = in_ready;
  assign out_o.valid         = out_valid_q;
  assign out_o.ppm           = ppm_q;
  assign out_o.level         = {1'b0, level_q};
  assign out_o.level_changed = changed_q;
  assign out_o.powered       = power_q;
  assign out_o.relay_on      = drive_q.relay;
  assign out_o.buzzer_on     = drive_q.buzz;
  assign out_o.led_red       = drive_q.red;
  assign out_o.led_green     = drive_q.green;
  assign out_o.led_blue      = drive_q.blue;
  assign out_o.blink_hz      = blink_q;

  // The ppm unit only reports while a sample is being worked on.
  a_done_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    calc_done |-> state_q == S_CALC)
    else $error("ppm unit finished outside a calculation");

  // A flagged change really moved the stored level.
  a_change_moves_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CALC && calc_done && changed_d) |=> level_q != $past(level_q))
    else $error("level change flagged without a new level");

  // While switched off the lamp is steady green and the outputs are dead.
  a_off_is_green: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !power_q |-> (drive_q == gpla_pkg::DRV_GREEN && blink_q == gpla_pkg::BLINK_OFF))
    else $error("drive active while powered off");

  // The buzzer never sounds without the relay and the red lamp.
  a_buzz_needs_relay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drive_q.buzz |-> (drive_q.relay && drive_q.red))
    else $error("buzzer on without relay and red lamp");

endmodule

`default_nettype wire

>>> tb/tb_gas_ppm_level_alarm_core.sv
`timescale 1ns / 1ps

module tb_gas_ppm_level_alarm_core;
  import gpla_pkg::*;

  localparam int                CODE_W       = ADC_BITS_DEF;
  localparam int                PPM_W        = PPM_BITS_DEF;
  localparam logic [CODE_W-1:0] CODE_FULL    = {CODE_W{1'b1}};
  localparam logic [PPM_W-1:0]  PPM_SAT      = {PPM_W{1'b1}};
  localparam logic [CFG_W-1:0]  THR_MAX      = {CFG_W{1'b1}};
  localparam longint            Q16_ONE      = 64'sd1 << LOG_FRAC;
  localparam int                SENSE_GAIN   = 15;

  // Op codes 5 to 7 have no meaning; the block must leave its state alone.
  localparam logic [2:0]           OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0]           OP_SPARE_LAST  = 3'd7;
  // Register index 3 is not decoded; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE      = 2'd3;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 12;
  // Long enough to cover the whole work on a sample inside the block.
  localparam int DRAIN_CYCLES = 80;
  // About 1300 items, even with the worst gaps and stalls, stay far below this.
  localparam int CYCLE_LIMIT  = 500000;
  localparam int MAX_REPORTS  = 10;
  localparam int PHASE_ITEMS  = 210;

  // One result item as the block reports it.
  typedef struct packed {
    logic [PPM_W-1:0] ppm;
    logic [2:0]       level;
    logic             changed;
    logic             powered;
    drive_t           drive;
    logic [2:0]       blink;
  } alarm_status_t;

  // Stall patterns of the result receiver.
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_pattern_e;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  gpla_in_if  #(.ADC_BITS(CODE_W)) in_ch ();
  gpla_out_if #(.PPM_BITS(PPM_W))  out_ch ();

  gas_ppm_level_alarm_core #(
    .ADC_BITS(CODE_W),
    .PPM_BITS(PPM_W)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch),
    .out_o     (out_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Predicted state of the alarm. It mirrors what the block must hold after
  // every accepted item, including the threshold registers.
  logic             pwr_on;
  logic [1:0]       alarm_lvl;
  logic [PPM_W-1:0] held_ppm;
  drive_t           drive_now;
  logic [2:0]       blink_now;
  logic [CFG_W-1:0] thr_low;
  logic [CFG_W-1:0] thr_high;
  logic [CFG_W-1:0] thr_alarm;

  // Factors 2^(2^-k) in Q30; entry i belongs to fraction bit i of log2(ppm).
  longint unsigned exp2_coef [LOG_FRAC];

  // Expected result items, oldest first.
  alarm_status_t status_q [$];

  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  burst_left;
  bit  steady_send;

  // Exact integer floor square root, built up one result bit at a time.
  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic void build_exp2_coef();
    longint unsigned c;
    c = floor_sqrt(64'd1 << (2 * Q_FRAC + 1));
    for (int i = LOG_FRAC - 1; i >= 0; i--) begin
      exp2_coef[i] = c;
      c = floor_sqrt(c << Q_FRAC);
    end
  endfunction

  // log2(x) in unsigned Q16. The integer part is the position of the top bit;
  // the fraction comes from squaring the Q30 mantissa and renormalizing.
  function automatic longint log2_fix(input longint unsigned x);
    int              top;
    longint unsigned mant;
    longint          acc;
    top = 0;
    for (int b = 0; b < 64; b++) if (x[b]) top = b;
    mant = x << (Q_FRAC - top);
    acc  = longint'(top) << LOG_FRAC;
    for (int i = LOG_FRAC - 1; i >= 0; i--) begin
      mant = (mant * mant) >> Q_FRAC;
      if (mant >= (64'd2 << Q_FRAC)) begin
        mant = mant >> 1;
        acc += longint'(1) << i;
      end
    end
    return acc;
  endfunction

  // Converter code to ppm: log2 of the sensor ratio, a linear map in the log
  // domain, then 2^y rebuilt from the fraction bits and shifted into place.
  function automatic logic [PPM_W-1:0] gas_ppm(input logic [CODE_W-1:0] code);
    longint unsigned sense;
    longint unsigned rest;
    longint unsigned whole;
    longint unsigned prod;
    longint unsigned scaled;
    longint          log_ratio;
    longint          log_ppm;
    if (code == '0) return '0;
    if (code == CODE_FULL) return PPM_SAT;
    sense     = code;
    sense     = sense * SENSE_GAIN;
    rest      = CODE_FULL - code;
    log_ratio = log2_fix(sense) - log2_fix(rest);
    log_ppm   = LOG_OFFSET + (LOG_SLOPE * log_ratio) / Q16_ONE;
    if (log_ppm < 0) return '0;
    whole = log_ppm >> LOG_FRAC;
    if (whole >= PPM_W) return PPM_SAT;
    prod = 64'd1 << Q_FRAC;
    for (int i = LOG_FRAC - 1; i >= 0; i--) begin
      if (log_ppm[i]) prod = (prod * exp2_coef[i]) >> Q_FRAC;
    end
    scaled = prod >> (Q_FRAC - whole);
    return (scaled > PPM_SAT) ? PPM_SAT : scaled[PPM_W-1:0];
  endfunction

  function automatic void set_power(input logic on);
    pwr_on    = on;
    drive_now = on ? DRV_BLUE : DRV_GREEN;
    blink_now = BLINK_OFF;
  endfunction

  function automatic void model_reset();
    thr_low   = LOW_RST;
    thr_high  = HIGH_RST;
    thr_alarm = ALARM_RST;
    alarm_lvl = 2'd0;
    held_ppm  = '0;
    set_power(1'b1);
  endfunction

  // Applies one accepted item to the predicted state and returns the result
  // item that the block must give for it.
  function automatic alarm_status_t predict_status(input logic [2:0] op,
                                                   input logic [CODE_W-1:0] code);
    alarm_status_t st;
    logic [1:0]    lvl_new;
    logic          moved;
    moved = 1'b0;
    case (op)
      OP_SAMPLE: begin
        if (pwr_on) begin
          held_ppm = gas_ppm(code);
          if (held_ppm < thr_low) lvl_new = 2'd0;
          else if (held_ppm < thr_high) lvl_new = 2'd1;
          else if (held_ppm < thr_alarm) lvl_new = 2'd2;
          else lvl_new = 2'd3;
          // The drive only moves when the level does.
          if (lvl_new != alarm_lvl) begin
            alarm_lvl = lvl_new;
            moved     = 1'b1;
            case (lvl_new)
              2'd0: begin drive_now = DRV_BLUE;   blink_now = BLINK_OFF; end
              2'd1: begin drive_now = DRV_LEVEL1; blink_now = BLINK_OFF; end
              2'd2: begin drive_now = DRV_LEVEL2; blink_now = BLINK_1HZ; end
              default: begin drive_now = DRV_LEVEL3; blink_now = BLINK_5HZ; end
            endcase
          end
        end
      end
      OP_TOGGLE:  set_power(~pwr_on);
      OP_PWR_ON:  set_power(1'b1);
      OP_PWR_OFF: set_power(1'b0);
      OP_RESET: begin
        alarm_lvl = 2'd0;
        held_ppm  = '0;
        set_power(1'b1);
      end
      default: ;
    endcase
    st.ppm     = held_ppm;
    st.level   = {1'b0, alarm_lvl};
    st.changed = moved;
    st.powered = pwr_on;
    st.drive   = drive_now;
    st.blink   = blink_now;
    return st;
  endfunction

  function automatic string show_status(input alarm_status_t s);
    return $sformatf("ppm=%0d level=%0d changed=%0b powered=%0b relay=%0b buzzer=%0b rgb=%0b%0b%0b blink=%0d",
                     s.ppm, s.level, s.changed, s.powered, s.drive.relay, s.drive.buzz,
                     s.drive.red, s.drive.green, s.drive.blue, s.blink);
  endfunction

  function automatic string field_diffs(input alarm_status_t want, input alarm_status_t got);
    string s;
    s = "";
    if (got.ppm !== want.ppm) s = {s, " ppm"};
    if (got.level !== want.level) s = {s, " level"};
    if (got.changed !== want.changed) s = {s, " level_changed"};
    if (got.powered !== want.powered) s = {s, " powered"};
    if (got.drive.relay !== want.drive.relay) s = {s, " relay_on"};
    if (got.drive.buzz !== want.drive.buzz) s = {s, " buzzer_on"};
    if (got.drive.red !== want.drive.red) s = {s, " led_red"};
    if (got.drive.green !== want.drive.green) s = {s, " led_green"};
    if (got.drive.blue !== want.drive.blue) s = {s, " led_blue"};
    if (got.blink !== want.blink) s = {s, " blink_hz"};
    return s;
  endfunction

  function automatic void note_failure(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%0t: %s", $time, what);
  endfunction

  // Result checker. Outputs are sampled at the rising edge, before any update
  // of that edge lands, and each accepted result item is matched against the
  // oldest prediction.
  alarm_status_t got_status;
  alarm_status_t want_status;
  string         bad_fields;

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got_status.ppm         = out_ch.ppm;
      got_status.level       = out_ch.level;
      got_status.changed     = out_ch.level_changed;
      got_status.powered     = out_ch.powered;
      got_status.drive.relay = out_ch.relay_on;
      got_status.drive.buzz  = out_ch.buzzer_on;
      got_status.drive.red   = out_ch.led_red;
      got_status.drive.green = out_ch.led_green;
      got_status.drive.blue  = out_ch.led_blue;
      got_status.blink       = out_ch.blink_hz;
      if (status_q.size() == 0) begin
        note_failure({"result item with none expected: ", show_status(got_status)});
      end else begin
        want_status = status_q.pop_front();
        bad_fields  = field_diffs(want_status, got_status);
        if (bad_fields != "") begin
          note_failure({"mismatch in", bad_fields, "\n  expected ", show_status(want_status),
                        "\n  actual   ", show_status(got_status)});
        end
      end
    end
  end

  // Result receiver. Every so often it picks a new stall pattern: always
  // ready, a coin toss per cycle, a fixed periodic stall, or a rare random
  // stall. The stretch lengths are random so that stalls land on every phase
  // of the block's work.
  initial begin
    rx_pattern_e rx_mode;
    int          rx_left;
    int          rx_tick;
    rx_mode = RX_OPEN;
    rx_left = 0;
    rx_tick = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_left == 0) begin
        rx_mode = rx_pattern_e'($urandom_range(0, 3));
        rx_left = $urandom_range(20, 120);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
        RX_OPEN:     out_ch.ready <= 1'b1;
        RX_COIN:     out_ch.ready <= ($urandom_range(0, 1) == 1);
        RX_PERIODIC: out_ch.ready <= ((rx_tick % 7) >= 3);
        default:     out_ch.ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Sends one item. Items go out in bursts of random length; between bursts
  // valid drops for a random gap unless the sender runs steady. Valid stays
  // high from one item to the next inside a burst. The prediction is made at
  // the edge where the item is accepted.
  task automatic send_item(input logic [2:0] op, input logic [CODE_W-1:0] code);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = steady_send ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_ch.valid    <= 1'b1;
    in_ch.op       <= op;
    in_ch.adc_code <= code;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    status_q.push_back(predict_status(op, code));
  endtask

  // Drops valid and waits until every expected result item has come back.
  // Every item gives a result, so the block is idle after that.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (status_q.size() != 0);
  endtask

  // One register write per edge. The enable is left high so that writes can
  // follow back to back; load_thresholds drops it at the end.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_LOW:   thr_low   = val;
      CFG_HIGH:  thr_high  = val;
      CFG_ALARM: thr_alarm = val;
      default: ;
    endcase
  endtask

  task automatic load_thresholds(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                                 input logic [CFG_W-1:0] al);
    write_reg(CFG_LOW, lo);
    write_reg(CFG_HIGH, hi);
    write_reg(CFG_ALARM, al);
    cfg_we_i <= 1'b0;
  endtask

  // Random traffic. Most items are samples, with power commands, the reset
  // command and unused op codes mixed in. Codes are uniform, with the ends of
  // the range and their neighbors drawn now and then. Every item sent counts
  // toward the total.
  task automatic random_traffic(input int count);
    int                done;
    int                pick;
    logic [2:0]        op;
    logic [CODE_W-1:0] code;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 74) op = OP_SAMPLE;
      else if (pick < 80) op = OP_TOGGLE;
      else if (pick < 88) op = OP_PWR_ON;
      else if (pick < 92) op = OP_PWR_OFF;
      else if (pick < 96) op = OP_RESET;
      else op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      case ($urandom_range(0, 31))
        0: code = '0;
        1: code = CODE_W'(1);
        2: code = CODE_FULL - CODE_W'(1);
        3: code = CODE_FULL;
        default: code = CODE_W'($urandom_range(0, CODE_FULL));
      endcase
      done++;
      send_item(op, code);
    end
  endtask

  // Power commands from both states, a sample while off, and the unused ops.
  task automatic test_power_commands();
    send_item(OP_TOGGLE, '0);
    send_item(OP_SAMPLE, 12'd3000);
    send_item(OP_PWR_OFF, CODE_FULL);
    send_item(OP_TOGGLE, '0);
    send_item(OP_PWR_ON, '0);
    send_item(OP_PWR_OFF, '0);
    send_item(OP_PWR_ON, 12'hFFF);
    for (int o = OP_SPARE_FIRST; o <= OP_SPARE_LAST; o++) send_item(3'(o), 12'hABC);
  endtask

  // Code zero, full scale with saturation, a repeat at the same level, the
  // codes next to both ends and mid-range bit patterns.
  task automatic test_code_extremes();
    send_item(OP_SAMPLE, '0);
    send_item(OP_SAMPLE, CODE_FULL);
    send_item(OP_SAMPLE, CODE_FULL);
    send_item(OP_SAMPLE, 12'd1);
    send_item(OP_SAMPLE, CODE_FULL - CODE_W'(1));
    send_item(OP_SAMPLE, 12'd2048);
    send_item(OP_SAMPLE, 12'h555);
    send_item(OP_SAMPLE, 12'hAAA);
  endtask

  // The reset command from the danger level and from the powered-off state.
  task automatic test_reset_command();
    send_item(OP_SAMPLE, CODE_FULL - CODE_W'(1));
    send_item(OP_RESET, '0);
    send_item(OP_SAMPLE, 12'd1);
    send_item(OP_TOGGLE, '0);
    send_item(OP_RESET, '0);
    send_item(OP_SAMPLE, 12'd2048);
  endtask

  task automatic test_default_thresholds();
    random_traffic(PHASE_ITEMS);
  endtask

  // All thresholds at zero: every powered sample is at the danger level.
  task automatic test_zero_thresholds();
    wait_idle();
    load_thresholds('0, '0, '0);
    random_traffic(PHASE_ITEMS);
  endtask

  // All thresholds at the top: only a saturated ppm reaches the danger level.
  task automatic test_max_thresholds();
    wait_idle();
    load_thresholds(THR_MAX, THR_MAX, THR_MAX);
    random_traffic(PHASE_ITEMS);
  endtask

  // Ordered thresholds in the busy part of the ppm range, with the sender
  // running without gaps.
  task automatic test_ordered_thresholds();
    logic [CFG_W-1:0] lo;
    logic [CFG_W-1:0] hi;
    logic [CFG_W-1:0] al;
    lo = CFG_W'($urandom_range(0, 400));
    hi = lo + CFG_W'($urandom_range(0, 800));
    al = hi + CFG_W'($urandom_range(0, 2000));
    wait_idle();
    load_thresholds(lo, hi, al);
    steady_send = 1'b1;
    random_traffic(PHASE_ITEMS);
    steady_send = 1'b0;
  endtask

  // Random thresholds over the whole range, in any order.
  task automatic test_crossed_thresholds();
    wait_idle();
    load_thresholds(CFG_W'($urandom_range(0, THR_MAX)), CFG_W'($urandom_range(0, THR_MAX)),
                    CFG_W'($urandom_range(0, THR_MAX)));
    random_traffic(PHASE_ITEMS);
  endtask

  // A write to the undecoded index must leave the thresholds alone; then the
  // reset values go back in.
  task automatic test_spare_register();
    wait_idle();
    write_reg(CFG_SPARE, CFG_W'($urandom_range(0, THR_MAX)));
    load_thresholds(LOW_RST, HIGH_RST, ALARM_RST);
    random_traffic(PHASE_ITEMS);
  endtask

  initial begin
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= CFG_LOW;
    cfg_data_i     <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.op       <= OP_SAMPLE;
    in_ch.adc_code <= '0;
    rst_ni         <= 1'b0;
    burst_left  = 0;
    steady_send = 1'b0;
    build_exp2_coef();
    model_reset();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_power_commands();
    test_code_extremes();
    test_reset_command();
    test_default_thresholds();
    test_zero_thresholds();
    test_max_thresholds();
    test_ordered_thresholds();
    test_crossed_thresholds();
    test_spare_register();

    // Let every result come back, then watch for stray result items.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> gas_ppm_level_alarm_core.f
rtl/core/gpla_pkg.sv
rtl/core/gpla_in_if.sv
rtl/core/gpla_out_if.sv
rtl/core/gpla_mul.sv
rtl/core/gpla_ppm_unit.sv
rtl/core/gas_ppm_level_alarm_core.sv
tb/tb_gas_ppm_level_alarm_core.sv
